[design/hosd_pkg.sv]
// Package for the hex octet string deframer: parser phases, result record,
// result kind codes and the hex digit decoder. No dependencies.
`default_nettype none

package hosd_pkg;

  // Parser phase within one frame LL:HH..HH CR LF
  typedef enum logic [2:0] {
    PH_LEN_HI = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_COLON  = 3'd2,
    PH_DAT_HI = 3'd3,
    PH_DAT_LO = 3'd4,
    PH_CR     = 3'd5,
    PH_LF     = 3'd6
  } phase_e;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [7:0] BAD_DIGIT    = 8'd255;
  localparam logic [7:0] MAX_BYTES_RST = 8'd20;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] length;
    logic       bad;
    logic       last;
  } result_t;

  // Map A-F, a-f, 0-9 to 0..15; anything else to 255
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = BAD_DIGIT;
    if (c inside {[8'd65:8'd70]}) v = c - 8'd55;
    else if (c inside {[8'd97:8'd102]}) v = c - 8'd87;
    else if (c inside {[8'd48:8'd57]}) v = c - 8'd48;
    return v;
  endfunction

  // (hi*16 + lo) mod 256
  function automatic logic [7:0] combine(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[3:0], 4'b0000} + lo;
  endfunction

endpackage

`default_nettype wire

[design/hex_octet_string_deframer.sv]
// Hex octet string deframer: top level with the max_bytes register.
// Depends on hosd_pkg, hosd_parser and hosd_skid.
//
// Usage:
//   Feed received characters on the input channel (in_valid_i/in_ready_o,
//   rx_char_i), one item per cycle at most. Frames look like LL:HH..HH CR LF;
//   LL is capped at max_bytes and that many hex pairs are decoded.
//   Each decoded byte comes out as a data item (result_kind_o = 0) and the LF
//   yields a frame-complete item (result_kind_o = 1) with the capped length
//   and the frame's bad-digit summary. Other characters produce no item.
//   The config channel (cfg_valid_i/cfg_ready_o, cfg_data_i) writes max_bytes;
//   it is always ready and should be written only while the block is idle.
// Timing:
//   A character is held in an input register and decoded from it there; the
//   result register loads the decoded result, which then drives the outputs.
//   Throughput is one character per cycle while the result side has room, set
//   by the single parse step between the input and result registers.
// Reset and stall:
//   Reset returns the parser to the first length digit, clears the pipeline
//   and sets max_bytes to 20. When the receiver stalls, the result register
//   and a skid entry hold two results and the input register one more
//   character; then input ready drops until the receiver drains.
`default_nettype none

module hex_octet_string_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_char_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic            result_kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      frame_length_o,
  output logic            bad_digit_o,
  output logic            last_o
);

  logic [7:0]        max_bytes_q;
  logic              push_valid;
  logic              push_ready;
  hosd_pkg::result_t push_data;
  hosd_pkg::result_t out_data;

  // Config register: always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= hosd_pkg::MAX_BYTES_RST;
    end else if (cfg_valid_i) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  // Input register and parse step
  hosd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_char_i    (rx_char_i),
    .max_bytes_i  (max_bytes_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Result register with skid entry
  hosd_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data)
  );

  // Unpack the result item onto its field ports
  assign result_kind_o  = out_data.kind;
  assign data_byte_o    = out_data.data;
  assign byte_index_o   = out_data.index;
  assign frame_length_o = out_data.length;
  assign bad_digit_o    = out_data.bad;
  assign last_o         = out_data.last;

endmodule

`default_nettype wire

[design/hosd_parser.sv]
// Input register and frame parser of the hex octet string deframer.
// Depends on hosd_pkg.
`default_nettype none

module hosd_parser (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_char_i,
  input  wire logic [7:0]       max_bytes_i,
  output logic                  push_valid_o,
  input  wire logic             push_ready_i,
  output hosd_pkg::result_t     push_data_o
);

  logic                 stage_valid_q;
  logic [7:0]           stage_char_q;
  logic                 advance;

  hosd_pkg::phase_e     phase_q, phase_d;
  logic [7:0]           held_q, held_d;
  logic [7:0]           count_q, count_d;
  logic [7:0]           pair_q, pair_d;
  logic                 err_q, err_d;

  logic [7:0]           dig;
  logic [7:0]           len_raw;
  logic                 fin;

  // Advance the held item whenever the result side has room
  assign advance    = stage_valid_q && push_ready_i;
  assign in_ready_o = !stage_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stage_char_q <= rx_char_i;
    end
  end

  assign dig     = hosd_pkg::digit_value(stage_char_q);
  assign len_raw = hosd_pkg::combine(held_q, dig);
  assign fin     = ({1'b0, pair_q} + 9'd1) >= {1'b0, count_q};

  // Next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    count_d = count_q;
    pair_d  = pair_q;
    err_d   = err_q;
    case (phase_q)
      hosd_pkg::PH_LEN_HI: begin
        err_d   = (dig == hosd_pkg::BAD_DIGIT);
        held_d  = dig;
        pair_d  = 8'd0;
        phase_d = hosd_pkg::PH_LEN_LO;
      end
      hosd_pkg::PH_LEN_LO: begin
        if (dig == hosd_pkg::BAD_DIGIT) err_d = 1'b1;
        count_d = (len_raw > max_bytes_i) ? max_bytes_i : len_raw;
        phase_d = hosd_pkg::PH_COLON;
      end
      hosd_pkg::PH_COLON: begin
        pair_d  = 8'd0;
        phase_d = (count_q == 8'd0) ? hosd_pkg::PH_CR : hosd_pkg::PH_DAT_HI;
      end
      hosd_pkg::PH_DAT_HI: begin
        held_d  = dig;
        if (dig == hosd_pkg::BAD_DIGIT) err_d = 1'b1;
        phase_d = hosd_pkg::PH_DAT_LO;
      end
      hosd_pkg::PH_DAT_LO: begin
        if (dig == hosd_pkg::BAD_DIGIT) err_d = 1'b1;
        if (fin) begin
          phase_d = hosd_pkg::PH_CR;
        end else begin
          pair_d  = pair_q + 8'd1;
          phase_d = hosd_pkg::PH_DAT_HI;
        end
      end
      hosd_pkg::PH_CR: begin
        phase_d = hosd_pkg::PH_LF;
      end
      default: begin
        phase_d = hosd_pkg::PH_LEN_HI;
      end
    endcase
  end

  // Result for the item in the stage
  always_comb begin
    push_valid_o       = 1'b0;
    push_data_o.kind   = hosd_pkg::KIND_DATA;
    push_data_o.data   = len_raw;
    push_data_o.index  = pair_q;
    push_data_o.length = count_q;
    push_data_o.bad    = (dig == hosd_pkg::BAD_DIGIT) || (held_q == hosd_pkg::BAD_DIGIT);
    push_data_o.last   = fin;
    case (phase_q)
      hosd_pkg::PH_DAT_LO: begin
        push_valid_o = advance;
      end
      hosd_pkg::PH_LF: begin
        push_valid_o      = advance;
        push_data_o.kind  = hosd_pkg::KIND_DONE;
        push_data_o.data  = 8'd0;
        push_data_o.index = 8'd0;
        push_data_o.bad   = err_q;
        push_data_o.last  = 1'b0;
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hosd_pkg::PH_LEN_HI;
      held_q  <= 8'd0;
      count_q <= 8'd0;
      pair_q  <= 8'd0;
      err_q   <= 1'b0;
    end else if (advance) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      count_q <= count_d;
      pair_q  <= pair_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

[design/hosd_skid.sv]
// Result register with a skid entry for the hex octet string deframer.
// Depends on hosd_pkg.
`default_nettype none

module hosd_skid (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire hosd_pkg::result_t  push_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output hosd_pkg::result_t       out_data_o
);

  logic              main_valid_q;
  logic              skid_valid_q;
  hosd_pkg::result_t main_q;
  hosd_pkg::result_t skid_q;

  assign push_ready_o = !skid_valid_q;
  assign out_valid_o  = main_valid_q;
  assign out_data_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_valid_i;
      end
    end else if (push_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !main_valid_q) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_valid_i) begin
        main_q <= push_data_i;
      end
    end else if (push_valid_i && !skid_valid_q) begin
      skid_q <= push_data_i;
    end
  end

endmodule

`default_nettype wire
